[design/assert_macros.svh]
// assertion helper macros for the quantizer design
// expects a clock i_clk and an active-low reset i_rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in quantizer");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in quantizer");

`endif

[design/uql_pkg.sv]
// shared constants for the uniform quantizer lookup block
// status codes, config register indexes and reset values; no dependencies
package uql_pkg;

    // default sample width
    localparam int UQL_VALUE_BITS = 16;

    // status codes
    localparam int STATUS_BITS = 2;
    localparam logic [STATUS_BITS-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_RANGE  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_CONFIG = 2'd2;

    // config register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_VALUE  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_VALUE  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_COUNT = 2'd2;

    // config reset values
    localparam int RST_MIN_VALUE  = 0;
    localparam int RST_MAX_VALUE  = 255;
    localparam int RST_STEP_COUNT = 8;

endpackage

[design/uniform_quantizer_lookup.sv]
// uniform scalar quantizer: sample in, level index, representative value and status out
// depends on uql_pkg and assert_macros.svh
//
//  channel   handshake                 payload
//  --------  ------------------------  -------------------------------------------
//  command   start / busy              i_sample
//  result    o_done (one-cycle strobe) o_level_index, o_recon_value, o_status
//  config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one sample is accepted every cycle while busy is low; each result passes through stage 1,
// the restoring divider stages (one quotient bit per stage), then cap, multiply and output stages
// after reset and after every config write, busy stays high while a serial divider works out
// the step size (max-min)/steps
// the result side cannot stall, so the pipeline never holds; o_done marks each result
// reset is synchronous and active low; config writes are always taken
`include "assert_macros.svh"

module uniform_quantizer_lookup #(
    parameter int VALUE_BITS = uql_pkg::UQL_VALUE_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // command channel
    input  logic                               start,
    output logic                               busy,
    input  logic signed [VALUE_BITS-1:0]       i_sample,
    // result channel
    output logic                               o_done,
    output logic [VALUE_BITS-1:0]              o_level_index,
    output logic signed [VALUE_BITS:0]         o_recon_value,
    output logic [uql_pkg::STATUS_BITS-1:0]    o_status,
    // config channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [uql_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [VALUE_BITS-1:0]              i_cfg_data
);
    import uql_pkg::*;

    localparam int W       = VALUE_BITS;
    localparam int CNT_W   = $clog2(W + 1);
    localparam int LATENCY = W + 4;

    // config registers and derived step size
    logic [W-1:0]     r_min_value;
    logic [W-1:0]     r_max_value;
    logic [W-1:0]     r_step_count;
    logic [W-1:0]     r_step_size;

    // serial divider for the step size
    logic             r_cd_pend;
    logic             r_cd_run;
    logic [CNT_W-1:0] r_cd_cnt;
    logic [W-1:0]     r_cd_rem;
    logic [W-1:0]     r_cd_num;
    logic [W-1:0]     r_cd_quo;
    logic [W:0]       cd_span;
    logic [W-1:0]     cd_rem_next;
    logic             cd_qbit;

    // stage 1: offset and status
    logic             r1_valid;
    logic [1:0]       r1_status;
    logic [W-1:0]     r1_d;
    logic [W-1:0]     r1_dm1;
    logic             r1_dzero;

    // divider stages
    logic             r_dv_valid  [W];
    logic [1:0]       r_dv_status [W];
    logic [W-1:0]     r_dv_d      [W];
    logic             r_dv_dzero  [W];
    logic [W-1:0]     r_dv_rem    [W];
    logic [W-1:0]     r_dv_num    [W];
    logic [W-1:0]     r_dv_quo    [W];
    logic [W-1:0]     n_dv_rem    [W];
    logic [W-1:0]     n_dv_num    [W];
    logic [W-1:0]     n_dv_quo    [W];

    // index cap, multiply and output stages
    logic             rc_valid;
    logic [1:0]       rc_status;
    logic [W-1:0]     rc_idx;
    logic             rp_valid;
    logic [1:0]       rp_status;
    logic [W-1:0]     rp_idx;
    logic [W-1:0]     rp_prod;
    logic             r_o_valid;
    logic [W-1:0]     r_o_idx;
    logic [W:0]       r_o_rec;
    logic [1:0]       r_o_status;

    logic             in_accept;
    logic             cfg_write;

    // one restoring division step: returns {quotient bit, new remainder}
    function automatic logic [W:0] div_step(input logic [W-1:0] rem, input logic nbit,
                                            input logic [W-1:0] divisor);
        logic [W:0] shifted;
        logic [W:0] diff;
        shifted = {rem, nbit};
        diff    = shifted - {1'b0, divisor};
        if (shifted >= {1'b0, divisor}) begin
            div_step = {1'b1, diff[W-1:0]};
        end else begin
            div_step = {1'b0, shifted[W-1:0]};
        end
    endfunction

    assign in_accept   = start && !busy;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign busy        = r_cd_pend || r_cd_run;
    // writes are always taken; each one restarts the step computation
    assign o_cfg_ready = 1'b1;

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_value  <= W'(RST_MIN_VALUE);
            r_max_value  <= W'(RST_MAX_VALUE);
            r_step_count <= W'(RST_STEP_COUNT);
        end else if (cfg_write) begin
            case (i_cfg_index)
                CFG_MIN_VALUE:  r_min_value  <= i_cfg_data;
                CFG_MAX_VALUE:  r_max_value  <= i_cfg_data;
                CFG_STEP_COUNT: r_step_count <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // step size divider datapath
    assign cd_span = {r_max_value[W-1], r_max_value} - {r_min_value[W-1], r_min_value};
    always_comb begin
        {cd_qbit, cd_rem_next} = div_step(r_cd_rem, r_cd_num[W-1], r_step_count);
    end

    // step size divider control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd_pend <= 1'b1;
            r_cd_run  <= 1'b0;
            r_cd_cnt  <= '0;
        end else if (cfg_write) begin
            r_cd_pend <= 1'b1;
            r_cd_run  <= 1'b0;
        end else if (r_cd_pend) begin
            r_cd_pend <= 1'b0;
            r_cd_run  <= 1'b1;
            r_cd_cnt  <= CNT_W'(W);
        end else if (r_cd_run) begin
            r_cd_cnt <= r_cd_cnt - 1'b1;
            if (r_cd_cnt == CNT_W'(1)) begin
                r_cd_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cd_pend) begin
            r_cd_rem <= '0;
            r_cd_num <= cd_span[W-1:0];
            r_cd_quo <= '0;
        end else if (r_cd_run) begin
            r_cd_rem <= cd_rem_next;
            r_cd_num <= {r_cd_num[W-2:0], 1'b0};
            r_cd_quo <= {r_cd_quo[W-2:0], cd_qbit};
            if (r_cd_cnt == CNT_W'(1)) begin
                r_step_size <= {r_cd_quo[W-2:0], cd_qbit};
            end
        end
    end

    // stage 1: offset from min and status
    logic [W:0] s1_d_full;
    logic       s1_cfg_bad;
    logic       s1_out_range;
    assign s1_d_full    = {i_sample[W-1], i_sample} - {r_min_value[W-1], r_min_value};
    assign s1_cfg_bad   = ($signed(r_min_value) >= $signed(r_max_value)) ||
                          (r_step_count <= W'(1));
    assign s1_out_range = (i_sample < $signed(r_min_value)) ||
                          (i_sample > $signed(r_max_value));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r1_d     <= s1_d_full[W-1:0];
            r1_dm1   <= s1_d_full[W-1:0] - 1'b1;
            r1_dzero <= (s1_d_full[W-1:0] == '0);
            if (s1_cfg_bad) begin
                r1_status <= ST_CONFIG;
            end else if (s1_out_range) begin
                r1_status <= ST_RANGE;
            end else begin
                r1_status <= ST_OK;
            end
        end
    end

    // divider stages: one quotient bit of (d-1)/s each
    always_comb begin
        logic [W:0] step_res;
        for (int k = 0; k < W; k++) begin
            if (k == 0) begin
                step_res    = div_step('0, r1_dm1[W-1], r_step_size);
                n_dv_num[k] = {r1_dm1[W-2:0], 1'b0};
                n_dv_quo[k] = {{(W-1){1'b0}}, step_res[W]};
            end else begin
                step_res    = div_step(r_dv_rem[k-1], r_dv_num[k-1][W-1], r_step_size);
                n_dv_num[k] = {r_dv_num[k-1][W-2:0], 1'b0};
                n_dv_quo[k] = {r_dv_quo[k-1][W-2:0], step_res[W]};
            end
            n_dv_rem[k] = step_res[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < W; k++) begin
                r_dv_valid[k] <= 1'b0;
            end
        end else begin
            r_dv_valid[0] <= r1_valid;
            for (int k = 1; k < W; k++) begin
                r_dv_valid[k] <= r_dv_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_status[0] <= r1_status;
        r_dv_d[0]      <= r1_d;
        r_dv_dzero[0]  <= r1_dzero;
        for (int k = 1; k < W; k++) begin
            r_dv_status[k] <= r_dv_status[k-1];
            r_dv_d[k]      <= r_dv_d[k-1];
            r_dv_dzero[k]  <= r_dv_dzero[k-1];
        end
        for (int k = 0; k < W; k++) begin
            r_dv_rem[k] <= n_dv_rem[k];
            r_dv_num[k] <= n_dv_num[k];
            r_dv_quo[k] <= n_dv_quo[k];
        end
    end

    // index select and cap at steps-1
    logic [W-1:0] sc_idx;
    logic [W-1:0] sc_last;
    assign sc_last = r_step_count - 1'b1;
    always_comb begin
        if (r_dv_dzero[W-1]) begin
            sc_idx = '0;
        end else if (r_step_size == '0) begin
            sc_idx = r_dv_d[W-1];
        end else begin
            sc_idx = r_dv_quo[W-1];
        end
    end

    // multiply stage operand
    logic [2*W-1:0] sp_prod_full;
    assign sp_prod_full = rc_idx * r_step_size;

    // output sum: min + index*s + (s+1)/2
    logic [W-1:0] so_half_sum;
    logic [W+1:0] so_rec;
    assign so_half_sum = r_step_size + 1'b1;
    assign so_rec      = {{2{r_min_value[W-1]}}, r_min_value} + {2'b00, rp_prod} +
                         {3'b000, so_half_sum[W-1:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rc_valid  <= 1'b0;
            rp_valid  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            rc_valid  <= r_dv_valid[W-1];
            rp_valid  <= rc_valid;
            r_o_valid <= rp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        rc_status <= r_dv_status[W-1];
        rc_idx    <= (sc_idx > sc_last) ? sc_last : sc_idx;
        rp_status <= rc_status;
        rp_idx    <= rc_idx;
        rp_prod   <= sp_prod_full[W-1:0];
        r_o_status <= rp_status;
        // fields are zero unless the status is ok
        if (rp_status == ST_OK) begin
            r_o_idx <= rp_idx;
            r_o_rec <= so_rec[W:0];
        end else begin
            r_o_idx <= '0;
            r_o_rec <= '0;
        end
    end

    assign o_done        = r_o_valid;
    assign o_level_index = r_o_idx;
    assign o_recon_value = $signed(r_o_rec);
    assign o_status      = r_o_status;

    // checks
    `ASSERT_IMPL(a_fixed_latency, start && !busy, ##LATENCY o_done)
    `ASSERT_IMPL(a_zero_when_bad, o_done && (o_status != ST_OK),
                 (o_level_index == '0) && (o_recon_value == '0))
    `ASSERT_NEXT(a_cfg_write_busy, i_cfg_valid && o_cfg_ready, busy)
    `ASSERT_IMPL(a_index_capped, o_done && (o_status == ST_OK),
                 o_level_index <= (r_step_count - 1'b1))

endmodule
